### rtl/circle_raster_canvas_core_defines.svh
// Assertion macros used by the checker of the circle raster canvas.
`ifndef CIRCLE_RASTER_CANVAS_CORE_DEFINES_SVH
`define CIRCLE_RASTER_CANVAS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define CRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/crc_pkg.sv
// Shared constants, codes and types of the circle raster canvas.
package crc_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int FRAC_BITS  = 8;

	localparam int FIELD_W    = 20;
	localparam int CHAR_W     = 8;
	localparam int DIM_W      = 10;
	localparam int MODE_W     = 2;
	localparam int RC_W       = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	// Squarer operand sizing: the larger of a pixel position and a field, plus a sign.
	localparam int POS_W  = ((ROW_W > COL_W) ? ROW_W : COL_W) + FRAC_BITS;
	localparam int SQ_W   = ((FIELD_W > POS_W) ? FIELD_W : POS_W) + 1;
	localparam int DIFF_W = SQ_W + 1;
	localparam int PROD_W = 2 * SQ_W;
	localparam int DIST_W = PROD_W + 1;

	localparam logic [DIFF_W-1:0] FIX_ONE = DIFF_W'(1) << FRAC_BITS;

	// Input tdata layout, lowest field first.
	localparam int CX_LSB    = 0;
	localparam int CY_LSB    = CX_LSB + FIELD_W;
	localparam int R_LSB     = CY_LSB + FIELD_W;
	localparam int CH_LSB    = R_LSB + FIELD_W;
	localparam int ROW_LSB   = CH_LSB + CHAR_W;
	localparam int COL_LSB   = ROW_LSB + RC_W;
	localparam int IN_BITS   = COL_LSB + RC_W;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((CHAR_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] RESET_BG     = CHAR_W'(32);
	localparam logic [DIM_W-1:0]  RESET_DIM    = DIM_W'(300);

	typedef enum logic [MODE_W-1:0] {
		MODE_OUTLINE,
		MODE_FILL,
		MODE_READ,
		MODE_CLEAR
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_BG
	} cfg_reg_t;

	// Operands of the shared squarer: it returns (a - b) squared.
	typedef struct packed {
		logic signed [DIFF_W-1:0] a;
		logic signed [DIFF_W-1:0] b;
	} sq_req_t;

endpackage

### rtl/crc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/crc_sqr.sv
// Shared difference-and-square unit with a registered product.
module crc_sqr (
	input  logic                        clk,
	input  crc_pkg::sq_req_t            req,
	output logic [crc_pkg::PROD_W-1:0]  prod
);

	logic signed [crc_pkg::DIFF_W-1:0] diff;
	logic [crc_pkg::SQ_W-1:0]          mag;
	logic [crc_pkg::PROD_W-1:0]        prod_q;

	always_comb begin
		diff = $signed(req.a) - $signed(req.b);
		mag  = diff[crc_pkg::DIFF_W-1] ? crc_pkg::SQ_W'(-diff) : crc_pkg::SQ_W'(diff);
	end

	always_ff @(posedge clk) begin
		prod_q <= crc_pkg::PROD_W'(mag) * crc_pkg::PROD_W'(mag);
	end

	assign prod = prod_q;

endmodule

### rtl/circle_raster_canvas_core.sv
// Circle raster canvas: a character store with outline and filled circle drawing.
// One item is worked on at a time and s_axis_tready is high only while the block is idle.
// A draw visits every pixel in use through one shared squarer, one pixel per cycle
// along a row, with a row step before each row. A draw while the error is set, one that
// flags an error, or one on a canvas with no row or no column in use goes straight to
// the result. A read inside the area in use goes through the store; one outside it
// does not. A clear sweeps the whole 262144-entry store one entry per cycle. After
// reset the same sweep loads the reset background, so s_axis_tready stays low until
// it ends; configuration writes are taken during that time. The result waits in an
// output register, so a slow consumer stalls only the next item's completion.
module circle_raster_canvas_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [crc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [crc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Command stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// center_x[19:0], center_y[39:20], radius[59:40], paint_char[67:60],
	// read_row[76:68], read_col[85:77], zero fill above.
	input  logic [crc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// mode[1:0]
	input  logic [crc_pkg::MODE_W-1:0]        s_axis_tuser,
	// Result stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_value[7:0]
	output logic [crc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// error_flag[0]
	output logic                              m_axis_tuser
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_SQR_R,
		ST_SQR_RI,
		ST_ROW,
		ST_COL,
		ST_DRAIN,
		ST_RD,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		TAG_NONE,
		TAG_R2,
		TAG_IN2,
		TAG_DY,
		TAG_DX
	} tag_t;

	state_t                          state_q;
	tag_t                            tag_q;
	logic [crc_pkg::ROW_W-1:0]       row_q;
	logic [crc_pkg::COL_W-1:0]       col_q;
	logic [crc_pkg::ADDR_W-1:0]      sweep_q;
	logic                            err_q;
	logic [crc_pkg::DIM_W-1:0]       width_q;
	logic [crc_pkg::DIM_W-1:0]       height_q;
	logic [crc_pkg::CHAR_W-1:0]      bg_q;
	logic                            valid_s2;
	logic                            out_valid_q;

	logic signed [crc_pkg::FIELD_W-1:0] cx_q;
	logic signed [crc_pkg::FIELD_W-1:0] cy_q;
	logic signed [crc_pkg::FIELD_W-1:0] r_q;
	logic [crc_pkg::CHAR_W-1:0]      ch_q;
	logic                            filled_q;
	logic [crc_pkg::PROD_W-1:0]      r2_q;
	logic [crc_pkg::PROD_W-1:0]      inner2_q;
	logic [crc_pkg::PROD_W-1:0]      dy2_q;
	logic [crc_pkg::ADDR_W-1:0]      addr_s1;
	logic [crc_pkg::ADDR_W-1:0]      addr_s2;
	logic [crc_pkg::DIST_W-1:0]      d2_s2;
	logic [crc_pkg::CHAR_W-1:0]      pixel_q;
	logic [crc_pkg::CHAR_W-1:0]      out_pixel_q;
	logic                            out_err_q;

	crc_pkg::mode_t                  in_mode;
	logic signed [crc_pkg::FIELD_W-1:0] in_cx;
	logic signed [crc_pkg::FIELD_W-1:0] in_cy;
	logic signed [crc_pkg::FIELD_W-1:0] in_r;
	logic [crc_pkg::CHAR_W-1:0]      in_ch;
	logic [crc_pkg::RC_W-1:0]        in_row;
	logic [crc_pkg::RC_W-1:0]        in_col;
	logic                            in_bad;
	logic                            in_range;

	logic [crc_pkg::DIM_W-1:0]       cols_use;
	logic [crc_pkg::DIM_W-1:0]       rows_use;
	logic                            col_last;
	logic                            row_last;
	logic                            sweep_last;
	logic                            sweeping;
	logic                            load_out;
	logic                            inner_ok;
	logic                            paint_s2;
	logic signed [crc_pkg::DIFF_W-1:0] r_ext;

	crc_pkg::sq_req_t                sq_req;
	logic [crc_pkg::PROD_W-1:0]      sq_prod;

	logic                            ram_we;
	logic [crc_pkg::ADDR_W-1:0]      ram_waddr;
	logic [crc_pkg::CHAR_W-1:0]      ram_wdata;
	logic [crc_pkg::ADDR_W-1:0]      ram_raddr;
	logic [crc_pkg::CHAR_W-1:0]      ram_rdata;

	// Field unpacking and command checks.
	always_comb begin
		in_mode = crc_pkg::mode_t'(s_axis_tuser);
		in_cx   = s_axis_tdata[crc_pkg::CX_LSB +: crc_pkg::FIELD_W];
		in_cy   = s_axis_tdata[crc_pkg::CY_LSB +: crc_pkg::FIELD_W];
		in_r    = s_axis_tdata[crc_pkg::R_LSB +: crc_pkg::FIELD_W];
		in_ch   = s_axis_tdata[crc_pkg::CH_LSB +: crc_pkg::CHAR_W];
		in_row  = s_axis_tdata[crc_pkg::ROW_LSB +: crc_pkg::RC_W];
		in_col  = s_axis_tdata[crc_pkg::COL_LSB +: crc_pkg::RC_W];

		in_bad = in_r[crc_pkg::FIELD_W-1] || (in_r == '0) || (in_ch == '0)
			|| (in_ch == crc_pkg::NEWLINE_CHAR) || (bg_q == crc_pkg::NEWLINE_CHAR);

		cols_use = (width_q > crc_pkg::DIM_W'(crc_pkg::MAX_WIDTH))
			? crc_pkg::DIM_W'(crc_pkg::MAX_WIDTH) : width_q;
		rows_use = (height_q > crc_pkg::DIM_W'(crc_pkg::MAX_HEIGHT))
			? crc_pkg::DIM_W'(crc_pkg::MAX_HEIGHT) : height_q;

		in_range = (crc_pkg::DIM_W'(in_row) < rows_use) && (crc_pkg::DIM_W'(in_col) < cols_use);
		col_last = (crc_pkg::DIM_W'(col_q) + crc_pkg::DIM_W'(1)) == cols_use;
		row_last = (crc_pkg::DIM_W'(row_q) + crc_pkg::DIM_W'(1)) == rows_use;
		sweep_last = sweep_q == crc_pkg::ADDR_W'(crc_pkg::RAM_DEPTH - 1);
		sweeping = (state_q == ST_INIT) || (state_q == ST_CLR);
		load_out = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);
	end

	// Paint decision on the registered squared distance.
	always_comb begin
		r_ext    = crc_pkg::DIFF_W'(r_q);
		inner_ok = r_ext >= $signed(crc_pkg::FIX_ONE);
		paint_s2 = valid_s2 && (d2_s2 <= crc_pkg::DIST_W'(r2_q))
			&& (filled_q || !inner_ok || (d2_s2 > crc_pkg::DIST_W'(inner2_q)));
	end

	// Operand selection for the shared squarer.
	always_comb begin
		sq_req.a = '0;
		sq_req.b = '0;
		case (state_q)
			ST_SQR_R: begin
				sq_req.a = r_ext;
			end
			ST_SQR_RI: begin
				sq_req.a = r_ext;
				sq_req.b = $signed(crc_pkg::FIX_ONE);
			end
			ST_ROW: begin
				sq_req.a = $signed(crc_pkg::DIFF_W'(row_q) << crc_pkg::FRAC_BITS);
				sq_req.b = crc_pkg::DIFF_W'(cy_q);
			end
			ST_COL: begin
				sq_req.a = $signed(crc_pkg::DIFF_W'(col_q) << crc_pkg::FRAC_BITS);
				sq_req.b = crc_pkg::DIFF_W'(cx_q);
			end
			default: begin
				sq_req.a = '0;
			end
		endcase
	end

	crc_sqr u_sqr (
		.clk  (clk),
		.req  (sq_req),
		.prod (sq_prod)
	);

	// Store write side: clearing sweep or painted pixel.
	always_comb begin
		ram_we    = sweeping || paint_s2;
		ram_waddr = sweeping ? sweep_q : addr_s2;
		if (state_q == ST_INIT) begin
			ram_wdata = crc_pkg::RESET_BG;
		end else if (state_q == ST_CLR) begin
			ram_wdata = bg_q;
		end else begin
			ram_wdata = ch_q;
		end
		ram_raddr = {crc_pkg::ROW_W'(in_row), crc_pkg::COL_W'(in_col)};
	end

	crc_ram #(
		.WIDTH (crc_pkg::CHAR_W),
		.DEPTH (crc_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, configuration registers and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			tag_q       <= TAG_NONE;
			row_q       <= '0;
			col_q       <= '0;
			sweep_q     <= '0;
			err_q       <= 1'b0;
			width_q     <= crc_pkg::RESET_DIM;
			height_q    <= crc_pkg::RESET_DIM;
			bg_q        <= crc_pkg::RESET_BG;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tag_q    <= TAG_NONE;
			valid_s2 <= tag_q == TAG_DX;

			if (cfg_we) begin
				case (cfg_idx)
					crc_pkg::REG_WIDTH:  width_q  <= cfg_wdata[crc_pkg::DIM_W-1:0];
					crc_pkg::REG_HEIGHT: height_q <= cfg_wdata[crc_pkg::DIM_W-1:0];
					crc_pkg::REG_BG:     bg_q     <= cfg_wdata[crc_pkg::CHAR_W-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						case (in_mode)
							crc_pkg::MODE_OUTLINE, crc_pkg::MODE_FILL: begin
								row_q <= '0;
								col_q <= '0;
								if (err_q) begin
									state_q <= ST_RESP;
								end else if (in_bad) begin
									err_q   <= 1'b1;
									state_q <= ST_RESP;
								end else if (rows_use == '0 || cols_use == '0) begin
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_SQR_R;
								end
							end
							crc_pkg::MODE_READ: begin
								state_q <= in_range ? ST_RD : ST_RESP;
							end
							default: begin
								sweep_q <= '0;
								state_q <= ST_CLR;
							end
						endcase
					end
				end
				ST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						err_q   <= bg_q == crc_pkg::NEWLINE_CHAR;
						state_q <= ST_RESP;
					end
				end
				ST_SQR_R: begin
					tag_q   <= TAG_R2;
					state_q <= ST_SQR_RI;
				end
				ST_SQR_RI: begin
					tag_q   <= TAG_IN2;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					tag_q   <= TAG_DY;
					state_q <= ST_COL;
				end
				ST_COL: begin
					tag_q <= TAG_DX;
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							state_q <= ST_DRAIN;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_ROW;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// The last pixels must be written before the result goes out.
					if (tag_q != TAG_DX && !valid_s2) begin
						state_q <= ST_RESP;
					end
				end
				ST_RD: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command payload, squares and the pixel pipeline.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cx_q     <= in_cx;
			cy_q     <= in_cy;
			r_q      <= in_r;
			ch_q     <= in_ch;
			filled_q <= in_mode == crc_pkg::MODE_FILL;
			pixel_q  <= '0;
		end
		if (state_q == ST_RD) begin
			pixel_q <= ram_rdata;
		end

		case (tag_q)
			TAG_R2:  r2_q     <= sq_prod;
			TAG_IN2: inner2_q <= sq_prod;
			TAG_DY:  dy2_q    <= sq_prod;
			default: ;
		endcase

		addr_s1 <= {row_q, col_q};
		addr_s2 <= addr_s1;
		d2_s2   <= crc_pkg::DIST_W'(dy2_q) + crc_pkg::DIST_W'(sq_prod);

		if (load_out) begin
			out_pixel_q <= pixel_q;
			out_err_q   <= err_q;
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = crc_pkg::M_TDATA_W'(out_pixel_q);
	assign m_axis_tuser  = out_err_q;

endmodule

### rtl/crc_chk.sv
// Port-level checker of the circle raster canvas and its bind.
`include "circle_raster_canvas_core_defines.svh"

module crc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [crc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser
);

	// A stalled result keeps its payload.
	`CRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// Every command keeps the block busy after its transfer: s_axis_tready drops once it is taken.
	`CRC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after a transfer")

	// A new result only comes out of work that was in progress.
	`CRC_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while idle")

endmodule

bind circle_raster_canvas_core crc_chk u_crc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
